### hw/rtl/btpc_pkg.sv
// Shared types and constants for the barometric compensation core.
package btpc_pkg;

  localparam int unsigned RawW   = 20;
  localparam int unsigned FineW  = 32;
  localparam int unsigned CentiW = 24;
  localparam int unsigned PressW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned DivSteps = 64;
  localparam int unsigned DivBitsPerStage = 2;

  localparam logic [CfgIdxW-1:0] RegTempCoeffs = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPressA     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPressB     = 2'd2;
  localparam logic [CfgIdxW-1:0] RegPressNine  = 2'd3;

  localparam logic signed [63:0] FineOffset = 64'sd128000;
  localparam logic signed [63:0] PressBase  = 64'sd1048576;
  localparam logic signed [63:0] ScaleK     = 64'sd3125;

  typedef struct packed {
    logic [RawW-1:0] raw_temperature;
    logic [RawW-1:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [FineW-1:0]  fine_temperature;
    logic signed [CentiW-1:0] temperature_centi;
    logic signed [PressW-1:0] pressure_q24_8;
    logic                     divisor_zero;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;

endpackage

### hw/rtl/btpc_if.sv
// Valid/ready channel interfaces for data and configuration.
interface btpc_in_if;
  import btpc_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface btpc_out_if;
  import btpc_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface btpc_cfg_if;
  import btpc_pkg::*;
  logic valid;
  logic ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/btpc_div_stage.sv
// One stage of the restoring divider: DivBitsPerStage quotient bits per stage.
module btpc_div_stage (
  input  logic [63:0] rem_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic [63:0] rem_o,
  output logic [63:0] num_o
);
  import btpc_pkg::*;

  logic [64:0] r;
  logic [63:0] n;
  logic [64:0] diff;

  always_comb begin
    r = {1'b0, rem_i};
    n = num_i;
    diff = '0;
    for (int i = 0; i < int'(DivBitsPerStage); i++) begin
      r = {r[63:0], n[63]};
      n = {n[62:0], 1'b0};
      diff = r - {1'b0, den_i};
      if (!diff[64]) begin
        r = diff;
        n[0] = 1'b1;
      end
    end
    rem_o = r[63:0];
    num_o = n;
  end
endmodule

### hw/rtl/baro_temp_pressure_compensation_core.sv
// Top level: pipelined integer temperature and pressure compensation.
//
//  channel  | dir | payload                                         | handshake
//  in_ch    | in  | raw_temperature, raw_pressure                   | valid/ready
//  out_ch   | out | fine, centi, pressure_q24_8, divisor_zero       | valid/ready
//  cfg_ch   | in  | index (2 bits), data (64 bits)                  | valid/ready
//
// One transaction per cycle in and out while out_ch.ready stays high. The pipeline
// runs from the accepting edge to out_ch.valid through 8 front stages, 32 divider
// stages (two quotient bits each), 4 back stages and the output register.
// The whole pipeline advances together; a stall at the output freezes every
// stage, so nothing is lost or repeated. Reset clears valid bits and coefficients.
// Configuration writes are always accepted.
module baro_temp_pressure_compensation_core (
  input logic clk_i,
  input logic rst_ni,
  btpc_in_if.sink    in_ch,
  btpc_out_if.source out_ch,
  btpc_cfg_if.sink   cfg_ch
);
  import btpc_pkg::*;

  localparam int unsigned DivStages = DivSteps / DivBitsPerStage;

  // coefficients
  logic [47:0] temp_q;
  logic [63:0] pa_q, pb_q;
  logic [15:0] p9_q;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0;
      pa_q <= '0;
      pb_q <= '0;
      p9_q <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        RegTempCoeffs: temp_q <= cfg_ch.data.data[47:0];
        RegPressA:     pa_q <= cfg_ch.data.data;
        RegPressB:     pb_q <= cfg_ch.data.data;
        RegPressNine:  p9_q <= cfg_ch.data.data[15:0];
        default: ;
      endcase
    end
  end

  logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {48'd0, temp_q[15:0]};
  assign t2 = 64'(signed'(temp_q[31:16]));
  assign t3 = 64'(signed'(temp_q[47:32]));
  assign p1 = {48'd0, pa_q[15:0]};
  assign p2 = 64'(signed'(pa_q[31:16]));
  assign p3 = 64'(signed'(pa_q[47:32]));
  assign p4 = 64'(signed'(pa_q[63:48]));
  assign p5 = 64'(signed'(pb_q[15:0]));
  assign p6 = 64'(signed'(pb_q[31:16]));
  assign p7 = 64'(signed'(pb_q[47:32]));
  assign p8 = 64'(signed'(pb_q[63:48]));
  assign p9 = 64'(signed'(p9_q));

  logic adv;
  logic out_valid_q;
  assign adv = !out_valid_q || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------- front stages: temperature and divider operands
  // s1
  logic v1_q; logic [19:0] adp1_q;
  logic signed [31:0] ta_q, tb_q;
  // s2
  logic v2_q; logic [19:0] adp2_q;
  logic signed [31:0] tv1_q, tbb_q;
  // s3
  logic v3_q; logic [19:0] adp3_q;
  logic signed [31:0] fine3_q;
  // s4
  logic v4_q; logic [19:0] adp4_q;
  logic signed [31:0] fine4_q; logic signed [23:0] centi4_q;
  logic signed [63:0] w4_q, w4sq_q;
  // s5
  logic v5_q; logic [19:0] adp5_q;
  logic signed [31:0] fine5_q; logic signed [23:0] centi5_q;
  logic signed [63:0] a5_q, b5_q, c5_q, d5_q;
  // s6
  logic v6_q;
  logic signed [31:0] fine6_q; logic signed [23:0] centi6_q;
  logic signed [63:0] x6_q, den6_q, pn6_q;
  // s7
  logic v7_q;
  logic signed [31:0] fine7_q; logic signed [23:0] centi7_q;
  logic signed [63:0] num7_q, den7_q;
  // s8: sign handling
  logic v8_q;
  logic signed [31:0] fine8_q; logic signed [23:0] centi8_q;
  logic [63:0] un8_q, ud8_q; logic neg8_q, dz8_q;

  logic signed [31:0] s1a, s1b, s2b;
  always_comb begin
    s1a = 32'(32'({12'd0, in_ch.data.raw_temperature} >> 3) - 32'(t1 << 1));
    s1b = 32'(32'({12'd0, in_ch.data.raw_temperature} >> 4) - 32'(t1));
    s2b = 32'(tbb_q) >>> 12;
  end

  logic signed [31:0] fine_c;
  assign fine_c = 32'(tv1_q + (32'(s2b * 32'(t3)) >>> 14));

  // fine - 128000 fits 33 bits, so the square is a 33 x 33 product
  logic signed [32:0] w_c;
  logic signed [65:0] wsq_c;
  assign w_c = 33'(fine3_q) - 33'sd128000;
  assign wsq_c = w_c * w_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_ch.valid; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
      v5_q <= v4_q; v6_q <= v5_q; v7_q <= v6_q; v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      adp1_q <= in_ch.data.raw_pressure;
      ta_q <= s1a; tb_q <= s1b;
      adp2_q <= adp1_q;
      tv1_q <= 32'(ta_q * 32'(t2)) >>> 11;
      tbb_q <= 32'(tb_q * tb_q);
      adp3_q <= adp2_q;
      fine3_q <= fine_c;
      adp4_q <= adp3_q;
      fine4_q <= fine3_q;
      centi4_q <= 24'(32'(32'(fine3_q * 32'sd5) + 32'sd128) >>> 8);
      w4_q <= 64'(w_c);
      w4sq_q <= wsq_c[63:0];
      adp5_q <= adp4_q; fine5_q <= fine4_q; centi5_q <= centi4_q;
      a5_q <= w4sq_q * p6;
      b5_q <= w4_q * p5;
      c5_q <= w4sq_q * p3;
      d5_q <= w4_q * p2;
      fine6_q <= fine5_q; centi6_q <= centi5_q;
      x6_q <= a5_q + (b5_q <<< 17) + (p4 <<< 35);
      den6_q <= (c5_q >>> 8) + (d5_q <<< 12);
      pn6_q <= PressBase - 64'(adp5_q);
      fine7_q <= fine6_q; centi7_q <= centi6_q;
      num7_q <= ((pn6_q <<< 31) - x6_q) * ScaleK;
      den7_q <= (((64'sd1 <<< 47) + den6_q) * p1) >>> 33;
      fine8_q <= fine7_q; centi8_q <= centi7_q;
      un8_q <= num7_q[63] ? 64'(-num7_q) : num7_q;
      ud8_q <= den7_q[63] ? 64'(-den7_q) : den7_q;
      neg8_q <= num7_q[63] ^ den7_q[63];
      dz8_q <= (den7_q == 64'sd0);
    end
  end

  // ---------------- divider stages
  logic [DivStages:1] dv_q;
  logic [63:0] drem_q [1:DivStages];
  logic [63:0] dnum_q [1:DivStages];
  logic [63:0] dden_q [1:DivStages];
  logic        dneg_q [1:DivStages];
  logic        ddz_q  [1:DivStages];
  logic [31:0] dfine_q [1:DivStages];
  logic [23:0] dcenti_q [1:DivStages];

  for (genvar g = 0; g < int'(DivStages); g++) begin : g_div
    logic        v_in, neg_in, dz_in;
    logic [63:0] rem_in, num_in, den_in;
    logic [31:0] fine_in;
    logic [23:0] centi_in;
    logic [63:0] rem_n, num_n;
    if (g == 0) begin : g_first
      assign v_in = v8_q;
      assign rem_in = '0;
      assign num_in = un8_q;
      assign den_in = ud8_q;
      assign neg_in = neg8_q;
      assign dz_in = dz8_q;
      assign fine_in = fine8_q;
      assign centi_in = centi8_q;
    end else begin : g_next
      assign v_in = dv_q[g];
      assign rem_in = drem_q[g];
      assign num_in = dnum_q[g];
      assign den_in = dden_q[g];
      assign neg_in = dneg_q[g];
      assign dz_in = ddz_q[g];
      assign fine_in = dfine_q[g];
      assign centi_in = dcenti_q[g];
    end
    btpc_div_stage u_stage (
      .rem_i(rem_in), .num_i(num_in), .den_i(den_in),
      .rem_o(rem_n), .num_o(num_n)
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[g+1] <= 1'b0;
      end else if (adv) begin
        dv_q[g+1] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        drem_q[g+1] <= rem_n; dnum_q[g+1] <= num_n; dden_q[g+1] <= den_in;
        dneg_q[g+1] <= neg_in; ddz_q[g+1] <= dz_in;
        dfine_q[g+1] <= fine_in; dcenti_q[g+1] <= centi_in;
      end
    end
  end

  // ---------------- back stages
  // P9 term is a 64-bit wrapped product, split into 32-bit partials over two stages
  logic q1v_q, q2v_q, q3v_q, q4v_q;
  logic signed [63:0] pq1_q, pa2_q, a2_q, pp2_q, m2_q, pp3_q, m1_q, pp4_q;
  logic [63:0] ll3_q;
  logic [31:0] x3_q;
  logic dz1_q, dz2_q, dz3_q, dz4_q;
  logic [31:0] f1_q, f2_q, f3_q, f4_q;
  logic [23:0] c1_q, c2_q, c3_q, c4_q;
  logic signed [63:0] qraw;
  assign qraw = dneg_q[DivStages] ? 64'(-dnum_q[DivStages]) : dnum_q[DivStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q1v_q <= 1'b0; q2v_q <= 1'b0; q3v_q <= 1'b0; q4v_q <= 1'b0;
    end else if (adv) begin
      q1v_q <= dv_q[DivStages]; q2v_q <= q1v_q; q3v_q <= q2v_q; q4v_q <= q3v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pq1_q <= qraw; dz1_q <= ddz_q[DivStages];
      f1_q <= dfine_q[DivStages]; c1_q <= dcenti_q[DivStages];
      pa2_q <= p9 * (pq1_q >>> 13);
      a2_q <= pq1_q >>> 13;
      pp2_q <= pq1_q;
      m2_q <= p8 * pq1_q;
      dz2_q <= dz1_q; f2_q <= f1_q; c2_q <= c1_q;
      ll3_q <= pa2_q[31:0] * a2_q[31:0];
      x3_q <= 32'(pa2_q[63:32] * a2_q[31:0]) + 32'(pa2_q[31:0] * a2_q[63:32]);
      pp3_q <= pp2_q + (m2_q >>> 19);
      dz3_q <= dz2_q; f3_q <= f2_q; c3_q <= c2_q;
      m1_q <= $signed(ll3_q + {x3_q, 32'd0}) >>> 25;
      pp4_q <= pp3_q;
      dz4_q <= dz3_q; f4_q <= f3_q; c4_q <= c3_q;
    end
  end

  logic signed [63:0] pfin;
  logic signed [31:0] psat;
  always_comb begin
    pfin = ((pp4_q + m1_q) >>> 8) + (p7 <<< 4);
    if (pfin > 64'sd2147483647) psat = 32'sh7FFFFFFF;
    else if (pfin < -64'sd2147483648) psat = 32'sh80000000;
    else psat = pfin[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= q4v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_ch.data.fine_temperature <= f4_q;
      out_ch.data.temperature_centi <= c4_q;
      out_ch.data.pressure_q24_8 <= dz4_q ? 32'sd0 : psat;
      out_ch.data.divisor_zero <= dz4_q;
    end
  end
  assign out_ch.valid = out_valid_q;

endmodule

### hw/rtl/btpc_checker.sv
// Port-level checker for the compensation core, bound to the top level.
module btpc_core_props (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid,
  input logic out_ready,
  input logic in_ready,
  input logic dz,
  input logic [31:0] press
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("output dropped");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready) else $error("input stalled with empty output");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && dz |-> press == 32'd0) else $error("zero divisor gave pressure");
endmodule

bind baro_temp_pressure_compensation_core btpc_core_props u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .in_ready(in_ch.ready),
  .dz(out_ch.data.divisor_zero), .press(out_ch.data.pressure_q24_8)
);

### dv/btpc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the compensation core: predicts each result and compares.
module btpc_checker
  import btpc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  btpc_in_if         in_ch,
  btpc_out_if        out_ch,
  btpc_cfg_if        cfg_ch,
  output int         fail_count_o,
  output int         pending_o
);

  logic [47:0] temp_coeffs;
  logic [63:0] press_a;
  logic [63:0] press_b;
  logic [15:0] press_nine;
  out_item_t   readings_due[$];

  function automatic logic [63:0] sx16(logic [63:0] v);
    return {{48{v[15]}}, v[15:0]};
  endfunction

  function automatic logic [63:0] sx32(logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic [63:0] sra(logic [63:0] v, int unsigned s);
    return $signed(v) >>> s;
  endfunction

  // Integer compensation: 32-bit wrap on the temperature side, 64-bit on pressure.
  function automatic out_item_t compensate(in_item_t it);
    logic [63:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] a, b, v1, v2, fine, centi, p, pq, num, un, ud, q;
    logic        flag;
    out_item_t   r;
    adc_t = 64'(it.raw_temperature);
    adc_p = 64'(it.raw_pressure);
    t1 = 64'(temp_coeffs[15:0]);
    t2 = sx16(64'(temp_coeffs[31:16]));
    t3 = sx16(64'(temp_coeffs[47:32]));
    p1 = 64'(press_a[15:0]);
    p2 = sx16(press_a >> 16);
    p3 = sx16(press_a >> 32);
    p4 = sx16(press_a >> 48);
    p5 = sx16(press_b);
    p6 = sx16(press_b >> 16);
    p7 = sx16(press_b >> 32);
    p8 = sx16(press_b >> 48);
    p9 = sx16(64'(press_nine));
    flag = 1'b0;
    pq = '0;

    a = sx32(((adc_t >> 3) - (t1 << 1)) * t2);
    v1 = sra(a, 11);
    b = (adc_t >> 4) - t1;
    b = sra(sx32(b * b), 12);
    v2 = sra(sx32(b * t3), 14);
    fine = sx32(v1 + v2);
    centi = sra(sx32(fine * 5 + 128), 8);

    v1 = fine - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = sra(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = sra(((64'd1 << 47) + v1) * p1, 33);

    if (v1 == 0) begin
      flag = 1'b1;
    end else begin
      p = 64'd1048576 - adc_p;
      num = ((p << 31) - v2) * 64'd3125;
      // truncating division on magnitudes; -2^63 / -1 wraps naturally
      un = num[63] ? -num : num;
      ud = v1[63] ? -v1 : v1;
      q = un / ud;
      p = (num[63] != v1[63]) ? -q : q;
      a = sra(p, 13);
      v1 = sra(p9 * a * a, 25);
      v2 = sra(p8 * p, 19);
      p = sra(p + v1 + v2, 8) + (p7 << 4);
      if (p + 64'h8000_0000 < 64'h1_0000_0000) pq = p;
      else if (p[63]) pq = 64'h8000_0000;
      else pq = 64'h7FFF_FFFF;
    end

    r.fine_temperature  = fine[31:0];
    r.temperature_centi = centi[23:0];
    r.pressure_q24_8    = pq[31:0];
    r.divisor_zero      = flag;
    return r;
  endfunction

  assign pending_o = readings_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      temp_coeffs  <= '0;
      press_a      <= '0;
      press_b      <= '0;
      press_nine   <= '0;
      fail_count_o <= 0;
      readings_due.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.index)
          RegTempCoeffs: temp_coeffs <= cfg_ch.data.data[47:0];
          RegPressA:     press_a     <= cfg_ch.data.data;
          RegPressB:     press_b     <= cfg_ch.data.data;
          RegPressNine:  press_nine  <= cfg_ch.data.data[15:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) readings_due.push_back(compensate(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (readings_due.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = readings_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch fine exp %0d got %0d, centi exp %0d got %0d",
                     $time, want.fine_temperature, got.fine_temperature,
                     want.temperature_centi, got.temperature_centi);
            $display("%0t:   pressure exp %0d got %0d, div0 exp %b got %b", $time,
                     want.pressure_q24_8, got.pressure_q24_8,
                     want.divisor_zero, got.divisor_zero);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

### dv/tb_baro_temp_pressure_compensation_core.sv
`timescale 1ns / 1ps
// Top-level testbench: stimulus, config phases, back-pressure and verdict.
module tb_baro_temp_pressure_compensation_core;
  import btpc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending;

  // long receiver hold-off: requested by stimulus, timed by the sink process
  logic hold_req;
  int   hold_left;
  logic hold_done;
  int   sink_mode;

  btpc_in_if  in_ch ();
  btpc_out_if out_ch ();
  btpc_cfg_if cfg_ch ();

  baro_temp_pressure_compensation_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  btpc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Sink side: stall pattern changes every so often; one long hold-off fills the pipe.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
      sink_mode    <= 0;
    end else if (hold_req && !hold_done && hold_left == 0) begin
      hold_left    <= 400;
      hold_done    <= 1'b1;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= (hold_left == 1);
    end else begin
      if ($urandom_range(0, 63) == 0) sink_mode <= $urandom_range(0, 3);
      case (sink_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= ($urandom_range(0, 1) != 0);
        default: out_ch.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  int burst_left;

  // One reading pair; the source runs in bursts with random gaps in between.
  task automatic send_reading(logic [RawW-1:0] rt, logic [RawW-1:0] rp);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    in_ch.valid                <= 1'b1;
    in_ch.data.raw_temperature <= rt;
    in_ch.data.raw_pressure    <= rp;
    forever begin
      @(negedge clk_i);
      if (in_ch.ready) break;
    end
    @(posedge clk_i);
    burst_left--;
  endtask

  // Drain the pipe, let any straggler clear, then write one register.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.data  <= val;
    forever begin
      @(negedge clk_i);
      if (cfg_ch.ready) break;
    end
    @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_coeffs(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb,
                             logic [15:0] p9);
    write_reg(RegTempCoeffs, {16'h0, tc});
    write_reg(RegPressA, pa);
    write_reg(RegPressB, pb);
    write_reg(RegPressNine, {{48{p9[15]}}, p9});
  endtask

  function automatic logic [15:0] jitter(logic [15:0] base);
    return base + 16'($urandom_range(0, 200)) - 16'd100;
  endfunction

  logic [47:0] typ_tc;
  logic [63:0] typ_pa, typ_pb;
  logic [15:0] typ_p9;

  initial begin
    logic [RawW-1:0] rt;
    logic [RawW-1:0] rp;
    rst_ni            = 1'b0;
    hold_req          = 1'b0;
    burst_left        = 0;
    in_ch.valid       <= 1'b0;
    in_ch.data        <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= '0;
    // typical factory trim
    typ_tc = {16'hFC18, 16'd26435, 16'd27504};
    typ_pa = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    typ_pb = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    typ_p9 = 16'd6000;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coefficients: divisor is zero for every reading.
    send_reading('0, '0);
    send_reading('1, '1);
    send_reading(20'h5A5A5, 20'hA5A5A);

    load_coeffs(typ_tc, typ_pa, typ_pb, typ_p9);
    send_reading(20'd519888, 20'd415148);
    send_reading('0, '0);
    send_reading('1, '1);
    send_reading('0, '1);
    send_reading('1, '0);
    send_reading(20'h80000, 20'h7FFFF);

    // Extreme coefficients: heavy wrap, saturation both ways.
    load_coeffs('1, '1, {4{16'h7FFF}}, 16'h7FFF);
    send_reading('0, '0);
    send_reading('1, '1);
    send_reading('1, '0);
    load_coeffs({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
                {4{16'h8000}}, 16'h8000);
    send_reading('0, '0);
    send_reading('1, '1);
    send_reading('0, '1);
    load_coeffs(typ_tc, {typ_pa[63:16], 16'd1}, {16'h7FFF, typ_pb[47:0]}, 16'h7FFF);
    send_reading('0, '0);
    send_reading('1, '1);
    send_reading(20'd519888, 20'd0);

    // Random phases: mostly near-typical trim, some fully random.
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 2) begin
        load_coeffs(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                    16'($urandom));
      end else begin
        load_coeffs({jitter(typ_tc[47:32]), jitter(typ_tc[31:16]), jitter(typ_tc[15:0])},
                    {jitter(typ_pa[63:48]), jitter(typ_pa[47:32]), jitter(typ_pa[31:16]),
                     (ph == 4) ? 16'd0 : jitter(typ_pa[15:0])},
                    {jitter(typ_pb[63:48]), jitter(typ_pb[47:32]), jitter(typ_pb[31:16]),
                     jitter(typ_pb[15:0])}, jitter(typ_p9));
      end
      for (int n = 0; n < 125; n++) begin
        if (ph == 1 && n == 20) hold_req = 1'b1;
        if ($urandom_range(0, 3) != 0) begin
          // realistic converter range
          rt = 20'($urandom_range(400000, 600000));
          rp = 20'($urandom_range(250000, 500000));
        end else begin
          rt = 20'($urandom);
          rp = 20'($urandom);
        end
        send_reading(rt, rp);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/btpc_pkg.sv
hw/rtl/btpc_if.sv
hw/rtl/btpc_div_stage.sv
hw/rtl/baro_temp_pressure_compensation_core.sv
hw/rtl/btpc_checker.sv
dv/btpc_checker.sv
dv/tb_baro_temp_pressure_compensation_core.sv
